// File: src/lhsc_pkg.sv
// -----------------------------------------------------------------------------
// lhsc_pkg
// shared types and codes for the handle slot cache: table entry layout,
// compare unit result, request modes and response status codes
// -----------------------------------------------------------------------------
package lhsc_pkg;

   localparam int GROUP_W  = 16;
   localparam int FILE_W   = 16;
   localparam int TIME_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;
   localparam int CLOSED_W = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_CHECKOUT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE_FILE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLOSE_GROUP = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_HIT         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OPENED      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OPEN_FAILED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED      = 3'd4;

   typedef struct packed {
      logic [GROUP_W-1:0] group_id;
      logic [FILE_W-1:0]  file_number;
      logic [TIME_W-1:0]  last_used;
   } entry_type;

   typedef struct packed {
      logic key_hit;
      logic group_hit;
      logic older;
   } cmp_type;

endpackage

// File: src/lhsc_cmp_unit.sv
// -----------------------------------------------------------------------------
// lhsc_cmp_unit
// shared compare unit: checks one table entry against the request key and
// against the oldest time seen so far in the scan
// -----------------------------------------------------------------------------
module lhsc_cmp_unit (
   input  lhsc_pkg::entry_type             entry,
   input  logic                            entry_open,
   input  logic [lhsc_pkg::GROUP_W-1:0]    group_id,
   input  logic [lhsc_pkg::FILE_W-1:0]     file_number,
   input  logic [lhsc_pkg::TIME_W-1:0]     best_time,
   output lhsc_pkg::cmp_type               result
);
   import lhsc_pkg::*;

   logic group_eq;

   assign group_eq         = (entry.group_id == group_id);
   assign result.group_hit = entry_open & group_eq;
   assign result.key_hit   = entry_open & group_eq & (entry.file_number == file_number);
   assign result.older     = (entry.last_used < best_time);

endmodule

// File: src/lru_handle_slot_cache.sv
// -----------------------------------------------------------------------------
// lru_handle_slot_cache
// fully associative table of open-handle slots with least recently used
// replacement; one shared compare unit walks the table one slot a cycle
// -----------------------------------------------------------------------------
// sequence: the scan state issues a read of each slot in turn and evaluates the
// slot read before it, then the result state registers the response and the strobe;
// a new word is taken only once the block is back in idle, not during a scan
// busy is high from the accepting edge until the strobe cycle; no stall on rsp
// reset: synchronous, clears all open bits and the sequencer, no clearing pass
// -----------------------------------------------------------------------------
module lru_handle_slot_cache #(
   parameter int SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lhsc_pkg::MODE_W-1:0]       req_mode,
   input  logic [lhsc_pkg::GROUP_W-1:0]      req_group_id,
   input  logic [lhsc_pkg::FILE_W-1:0]       req_file_number,
   input  logic                              req_want_write,
   input  logic [lhsc_pkg::TIME_W-1:0]       req_now,
   input  logic                              req_open_ok,
   output logic                              rsp_valid,
   output logic [lhsc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lhsc_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [lhsc_pkg::CLOSED_W-1:0]     rsp_closed_slots,
   output logic                              rsp_flush_needed
);
   import lhsc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type state_ff, state_in;

   // latched request
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [FILE_W-1:0]  file_ff, file_in;
   logic               want_write_ff, want_write_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               open_ok_ff, open_ok_in;

   // slot status bits
   logic [SLOTS-1:0] open_ff, open_in;
   logic [SLOTS-1:0] writable_ff, writable_in;

   // scan sequencer
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;

   // scan trackers
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               first_ff, first_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]  best_time_ff, best_time_in;
   logic [CLOSED_W-1:0] closed_ff, closed_in;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [CLOSED_W-1:0] rsp_closed_ff, rsp_closed_in;
   logic                rsp_flush_ff, rsp_flush_in;

   // entry memory
   entry_type        mem [SLOTS];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   cmp_type          cmp;
   logic             hit_ok;
   logic [IDX_W-1:0] target;

   lhsc_cmp_unit u_cmp (
      .entry       (rd_data_ff),
      .entry_open  (open_ff[ev_idx_ff]),
      .group_id    (group_ff),
      .file_number (file_ff),
      .best_time   (best_time_ff),
      .result      (cmp)
   );

   assign rd_en   = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(SLOTS));
   assign rd_addr = cnt_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign hit_ok = found_ff && !(want_write_ff && !writable_ff[match_idx_ff]);
   assign target = found_ff ? match_idx_ff : (free_found_ff ? free_idx_ff : best_idx_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      group_in      = group_ff;
      file_in       = file_ff;
      want_write_in = want_write_ff;
      now_in        = now_ff;
      open_ok_in    = open_ok_ff;
      open_in       = open_ff;
      writable_in   = writable_ff;
      cnt_in        = cnt_ff;
      ev_valid_in   = 1'b0;
      ev_idx_in     = ev_idx_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      first_in      = first_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      closed_in     = closed_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_flush_in  = rsp_flush_ff;
      mem_we        = 1'b0;
      mem_waddr     = match_idx_ff;
      mem_wdata     = '{group_id: group_ff, file_number: file_ff, last_used: now_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in       = req_mode;
               group_in      = req_group_id;
               file_in       = req_file_number;
               want_write_in = req_want_write;
               now_in        = req_now;
               open_ok_in    = req_open_ok;
               cnt_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               first_in      = 1'b1;
               closed_in     = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of slot cnt is issued now, slot cnt-1 is evaluated now
            if (cnt_ff < CNT_W'(SLOTS)) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
            if (ev_valid_ff) begin
               if (cmp.key_hit && !found_ff) begin
                  found_in     = 1'b1;
                  match_idx_in = ev_idx_ff;
               end
               if (!open_ff[ev_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = ev_idx_ff;
               end
               // strictly older wins, so ties stay with the lowest index
               if (first_ff || cmp.older) begin
                  first_in     = 1'b0;
                  best_idx_in  = ev_idx_ff;
                  best_time_in = rd_data_ff.last_used;
               end
               if (mode_ff == MODE_CLOSE_GROUP && cmp.group_hit) begin
                  open_in[ev_idx_ff] = 1'b0;
                  closed_in = closed_ff | (CLOSED_W'(1) << ev_idx_ff);
               end
            end
         end
         ST_DONE: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_NOT_FOUND;
            rsp_slot_in   = '0;
            rsp_closed_in = '0;
            rsp_flush_in  = 1'b0;
            unique case (mode_ff)
               MODE_CHECKOUT: begin
                  if (hit_ok) begin
                     mem_we        = 1'b1;
                     rsp_status_in = STATUS_HIT;
                     rsp_slot_in   = SLOT_W'(match_idx_ff);
                  end else begin
                     mem_waddr   = target;
                     rsp_slot_in = SLOT_W'(target);
                     if (open_ff[target]) begin
                        open_in[target] = 1'b0;
                        rsp_closed_in   = CLOSED_W'(1) << target;
                     end
                     if (open_ok_ff) begin
                        open_in[target]     = 1'b1;
                        writable_in[target] = want_write_ff;
                        mem_we              = 1'b1;
                        rsp_status_in       = STATUS_OPENED;
                     end else begin
                        rsp_status_in = STATUS_OPEN_FAILED;
                     end
                  end
               end
               MODE_LOOKUP: begin
                  if (hit_ok) begin
                     mem_we        = 1'b1;
                     rsp_status_in = STATUS_HIT;
                     rsp_slot_in   = SLOT_W'(match_idx_ff);
                  end
               end
               MODE_CLOSE_FILE: begin
                  if (found_ff) begin
                     open_in[match_idx_ff] = 1'b0;
                     rsp_flush_in  = writable_ff[match_idx_ff];
                     rsp_closed_in = CLOSED_W'(1) << match_idx_ff;
                     rsp_status_in = STATUS_CLOSED;
                     rsp_slot_in   = SLOT_W'(match_idx_ff);
                  end
               end
               MODE_CLOSE_GROUP: begin
                  rsp_status_in = STATUS_CLOSED;
                  rsp_closed_in = closed_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         writable_ff  <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         writable_ff  <= writable_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      group_ff      <= group_in;
      file_ff       <= file_in;
      want_write_ff <= want_write_in;
      now_ff        <= now_in;
      open_ok_ff    <= open_ok_in;
      cnt_ff        <= cnt_in;
      ev_idx_ff     <= ev_idx_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      first_ff      <= first_in;
      best_idx_ff   <= best_idx_in;
      best_time_ff  <= best_time_in;
      closed_ff     <= closed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_flush_ff  <= rsp_flush_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_closed_slots = rsp_closed_ff;
   assign rsp_flush_needed = rsp_flush_ff;

endmodule

// File: src/lhsc_checker.sv
// -----------------------------------------------------------------------------
// lhsc_checker
// port-level checks on the handle slot cache: sequencing and response coding
// -----------------------------------------------------------------------------
module lhsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [lhsc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [lhsc_pkg::SLOT_W-1:0]       rsp_slot,
   input logic [lhsc_pkg::CLOSED_W-1:0]     rsp_closed_slots,
   input logic                              rsp_flush_needed
);
   import lhsc_pkg::*;

   // an accepted word keeps the block busy for the scan
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // one strobe per word, never back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_not_found_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NOT_FOUND) |->
         (rsp_slot == '0 && rsp_closed_slots == '0 && !rsp_flush_needed))
      else $error("not-found response carries slot or close data");

   // flush only comes from a single file close, and a hit closes nothing
   a_flush_only_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flush_needed) |-> (rsp_status == STATUS_CLOSED))
      else $error("flush flagged on a non-close response");

   a_hit_closes_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_HIT) |-> (rsp_closed_slots == '0))
      else $error("hit response reports closed slots");

endmodule

bind lru_handle_slot_cache lhsc_checker u_lhsc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_slot         (rsp_slot),
   .rsp_closed_slots (rsp_closed_slots),
   .rsp_flush_needed (rsp_flush_needed)
);
